@@ src/tdc_pkg.sv @@
// ============================================================================
// Tolerant double compare package
// Shared constants, types and helpers for the comparator pipeline.
// ============================================================================
package tdc_pkg;

    // Number of pipeline register stages, from the input register to the result.
    localparam int NSTG = 10;
    localparam int LAST = NSTG - 1;

    localparam logic [62:0] INF_MAG = 63'h7FF0_0000_0000_0000;

    // Equality test selection.
    localparam logic [2:0] MODE_ABS     = 3'd0;
    localparam logic [2:0] MODE_REL     = 3'd1;
    localparam logic [2:0] MODE_ABS_REL = 3'd2;
    localparam logic [2:0] MODE_ULP     = 3'd3;
    localparam logic [2:0] MODE_ABS_ULP = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_ABS  = 2'd1;
    localparam logic [1:0] REG_REL  = 2'd2;
    localparam logic [1:0] REG_ULP  = 2'd3;

    // Result codes.
    localparam logic signed [1:0] ORDER_EQ = 2'sb00;
    localparam logic signed [1:0] ORDER_GT = 2'sb01;
    localparam logic signed [1:0] ORDER_LT = 2'sb11;

    // Magnitude of a - b.
    typedef struct packed {
        logic        nan;
        logic [62:0] mag;
    } diff_t;

    // max(|a|,|b|) times the relative factor.
    typedef struct packed {
        logic        nan;
        logic        neg;
        logic [62:0] mag;
    } prod_t;

    function automatic logic is_nan63(input logic [62:0] m);
        return (m[62:52] == 11'h7FF) && (m[51:0] != 52'd0);
    endfunction

    function automatic logic is_inf63(input logic [62:0] m);
        return m == INF_MAG;
    endfunction

    function automatic logic [52:0] mant(input logic [62:0] m);
        return {m[62:52] != 11'd0, m[51:0]};
    endfunction

    function automatic logic [10:0] expo(input logic [62:0] m);
        return (m[62:52] == 11'd0) ? 11'd1 : m[62:52];
    endfunction

    // Leading zero count of a 106-bit word; 106 when the word is zero.
    function automatic logic [6:0] lzc106(input logic [105:0] v);
        logic [6:0] n;
        n = 7'd106;
        for (int i = 0; i < 106; i++) begin
            if (v[i]) begin
                n = 7'(105 - i);
            end
        end
        return n;
    endfunction

    // Double compare |d| <= y, false when either side is NaN.
    function automatic logic tol_le(input diff_t d, input logic [62:0] ymag,
                                    input logic yneg, input logic ynan);
        logic ok;
        if (d.nan || ynan) begin
            ok = 1'b0;
        end
        else if (yneg) begin
            ok = (d.mag == 63'd0) && (ymag == 63'd0);
        end
        else begin
            ok = d.mag <= ymag;
        end
        return ok;
    endfunction

endpackage

@@ src/tdc_sub.sv @@
// ============================================================================
// Magnitude subtractor
// Computes |a - b| in double precision, rounded to nearest even, over
// stages 1 to 6, then carries it to stage 8.
// ============================================================================
module tdc_sub
    import tdc_pkg::*;
(
    input  logic            clk,
    input  logic [NSTG-1:0] en,
    input  logic [63:0]     a,
    input  logic [63:0]     b,
    output logic [62:0]     big_mag,
    output diff_t           diff
);

    // Stage 1: order the magnitudes.
    logic [62:0] x1_reg, y1_reg;
    logic        sub1_reg, nan1_reg, inf1_reg;
    logic        a_inf, b_inf, same_sign;

    assign a_inf     = is_inf63(a[62:0]);
    assign b_inf     = is_inf63(b[62:0]);
    assign same_sign = a[63] == b[63];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            x1_reg   <= (a[62:0] >= b[62:0]) ? a[62:0] : b[62:0];
            y1_reg   <= (a[62:0] >= b[62:0]) ? b[62:0] : a[62:0];
            sub1_reg <= same_sign;
            nan1_reg <= a_inf && b_inf && same_sign;
            inf1_reg <= (a_inf || b_inf) && !(a_inf && b_inf && same_sign);
        end
    end

    assign big_mag = x1_reg;

    // Stage 2: align the smaller operand, keeping guard, round and sticky.
    logic [55:0]  mx2_reg, ys2_reg;
    logic [10:0]  ex2_reg;
    logic         sub2_reg, nan2_reg, inf2_reg;
    logic [10:0]  d2;
    logic [5:0]   dcap2;
    logic [119:0] wide2;

    assign d2    = expo(x1_reg) - expo(y1_reg);
    assign dcap2 = (d2[10:6] != 5'd0) ? 6'd63 : d2[5:0];
    assign wide2 = {mant(y1_reg), 3'b000, 64'd0} >> dcap2;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            mx2_reg  <= {mant(x1_reg), 3'b000};
            ys2_reg  <= {wide2[119:65], wide2[64] | (wide2[63:0] != 64'd0)};
            ex2_reg  <= expo(x1_reg);
            sub2_reg <= sub1_reg;
            nan2_reg <= nan1_reg;
            inf2_reg <= inf1_reg;
        end
    end

    // Stage 3: add or subtract.
    logic [56:0] s3_reg;
    logic [10:0] ex3_reg;
    logic        nan3_reg, inf3_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_reg   <= sub2_reg ? ({1'b0, mx2_reg} - {1'b0, ys2_reg})
                                 : ({1'b0, mx2_reg} + {1'b0, ys2_reg});
            ex3_reg  <= ex2_reg;
            nan3_reg <= nan2_reg;
            inf3_reg <= inf2_reg;
        end
    end

    // Stage 4: fold the carry, find the normalizing shift.
    logic [55:0] t4;
    logic [11:0] e4, lim4;
    logic [6:0]  lz4;
    logic [55:0] t4_reg;
    logic [11:0] e4_reg;
    logic [6:0]  sh4_reg;
    logic        zero4_reg, nan4_reg, inf4_reg;

    assign t4   = s3_reg[56] ? {s3_reg[56:2], s3_reg[1] | s3_reg[0]} : s3_reg[55:0];
    assign e4   = {1'b0, ex3_reg} + {11'd0, s3_reg[56]};
    assign lim4 = e4 - 12'd1;
    assign lz4  = lzc106({t4, 50'd0});

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            t4_reg    <= t4;
            e4_reg    <= e4;
            sh4_reg   <= (lim4 < {5'd0, lz4}) ? lim4[6:0] : lz4;
            zero4_reg <= t4 == 56'd0;
            nan4_reg  <= nan3_reg;
            inf4_reg  <= inf3_reg;
        end
    end

    // Stage 5: normalize.
    logic [55:0] t5_reg;
    logic [11:0] e5_reg;
    logic        zero5_reg, nan5_reg, inf5_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            t5_reg    <= t4_reg << sh4_reg;
            e5_reg    <= e4_reg - {5'd0, sh4_reg};
            zero5_reg <= zero4_reg;
            nan5_reg  <= nan4_reg;
            inf5_reg  <= inf4_reg;
        end
    end

    // Stage 6: pack and round; a rounding carry walks into the exponent.
    logic        rnd6;
    logic [11:0] em1_6;
    logic [62:0] packed6;
    diff_t       d6_reg, d7_reg, d8_reg;

    assign rnd6    = t5_reg[2] & (t5_reg[1] | t5_reg[0] | t5_reg[3]);
    assign em1_6   = e5_reg - 12'd1;
    assign packed6 = {em1_6[10:0], 52'd0} + {10'd0, t5_reg[55:3]} + {62'd0, rnd6};

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            d6_reg.nan <= nan5_reg;
            if (inf5_reg || e5_reg >= 12'd2047)
            begin
                d6_reg.mag <= INF_MAG;
            end
            else if (zero5_reg)
            begin
                d6_reg.mag <= 63'd0;
            end
            else
            begin
                d6_reg.mag <= packed6;
            end
        end
        if (en[7])
        begin
            d7_reg <= d6_reg;
        end
        if (en[8])
        begin
            d8_reg <= d7_reg;
        end
    end

    assign diff = d8_reg;

endmodule

@@ src/tdc_mul.sv @@
// ============================================================================
// Tolerance multiplier
// Computes max(|a|,|b|) times the relative factor in double precision,
// rounded to nearest even, over stages 2 to 8.
// ============================================================================
module tdc_mul
    import tdc_pkg::*;
(
    input  logic            clk,
    input  logic [NSTG-1:0] en,
    input  logic [62:0]     big_mag,
    input  logic [63:0]     factor,
    output prod_t           prod
);

    // Stage 2: four partial products of at most 27 by 27 bits.
    logic [52:0] mb, mr;
    logic        b_nan, r_nan, b_inf, r_inf, b_zero, r_zero, nan2;
    logic [51:0] hh2_reg;
    logic [52:0] hl2_reg, lh2_reg;
    logic [53:0] ll2_reg;
    logic [11:0] es2_reg;
    logic        nan2_reg, inf2_reg, zero2_reg, neg2_reg;

    assign mb     = mant(big_mag);
    assign mr     = mant(factor[62:0]);
    assign b_nan  = is_nan63(big_mag);
    assign r_nan  = is_nan63(factor[62:0]);
    assign b_inf  = is_inf63(big_mag);
    assign r_inf  = is_inf63(factor[62:0]);
    assign b_zero = big_mag == 63'd0;
    assign r_zero = factor[62:0] == 63'd0;
    assign nan2   = b_nan || r_nan || (b_inf && r_zero) || (r_inf && b_zero);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            hh2_reg   <= {26'd0, mb[52:27]} * {26'd0, mr[52:27]};
            hl2_reg   <= {27'd0, mb[52:27]} * {26'd0, mr[26:0]};
            lh2_reg   <= {26'd0, mb[26:0]} * {27'd0, mr[52:27]};
            ll2_reg   <= {27'd0, mb[26:0]} * {27'd0, mr[26:0]};
            es2_reg   <= {1'b0, expo(big_mag)} + {1'b0, expo(factor[62:0])};
            nan2_reg  <= nan2;
            inf2_reg  <= (b_inf || r_inf) && !nan2;
            zero2_reg <= (b_zero || r_zero) && !nan2;
            neg2_reg  <= factor[63];
        end
    end

    // Stage 3: middle terms. Stage 4: full 106-bit product.
    logic [51:0]  hh3_reg;
    logic [53:0]  ll3_reg, cr3_reg;
    logic [105:0] p4_reg;
    logic [11:0]  es3_reg, es4_reg;
    logic         nan3_reg, inf3_reg, zero3_reg, neg3_reg;
    logic         nan4_reg, inf4_reg, zero4_reg, neg4_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            hh3_reg   <= hh2_reg;
            ll3_reg   <= ll2_reg;
            cr3_reg   <= {1'b0, hl2_reg} + {1'b0, lh2_reg};
            es3_reg   <= es2_reg;
            nan3_reg  <= nan2_reg;
            inf3_reg  <= inf2_reg;
            zero3_reg <= zero2_reg;
            neg3_reg  <= neg2_reg;
        end
        if (en[4])
        begin
            p4_reg    <= {hh3_reg, ll3_reg} + {25'd0, cr3_reg, 27'd0};
            es4_reg   <= es3_reg;
            nan4_reg  <= nan3_reg;
            inf4_reg  <= inf3_reg;
            zero4_reg <= zero3_reg;
            neg4_reg  <= neg3_reg;
        end
    end

    // Stage 5: leading zeros and the unbounded result exponent.
    logic [6:0]         lz5;
    logic [105:0]       p5_reg;
    logic [6:0]         lz5_reg;
    logic signed [13:0] e5_reg;
    logic               nan5_reg, inf5_reg, zero5_reg, neg5_reg;

    assign lz5 = lzc106(p4_reg);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            p5_reg    <= p4_reg;
            lz5_reg   <= lz5;
            e5_reg    <= $signed({2'b00, es4_reg}) - 14'sd1022 - $signed({7'd0, lz5});
            nan5_reg  <= nan4_reg;
            inf5_reg  <= inf4_reg;
            zero5_reg <= zero4_reg;
            neg5_reg  <= neg4_reg;
        end
    end

    // Stage 6: normalize left; work out the subnormal right shift.
    logic signed [13:0] under6;
    logic [105:0]       n6_reg;
    logic [6:0]         rs6_reg;
    logic [10:0]        ef6_reg;
    logic               ovf6_reg, nan6_reg, inf6_reg, zero6_reg, neg6_reg;

    assign under6 = 14'sd1 - e5_reg;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            n6_reg <= p5_reg << lz5_reg;
            if (e5_reg < 14'sd1)
            begin
                rs6_reg <= (under6 > 14'sd127) ? 7'd127 : under6[6:0];
                ef6_reg <= 11'd1;
            end
            else
            begin
                rs6_reg <= 7'd0;
                ef6_reg <= e5_reg[10:0];
            end
            ovf6_reg  <= e5_reg >= 14'sd2047;
            nan6_reg  <= nan5_reg;
            inf6_reg  <= inf5_reg;
            zero6_reg <= zero5_reg;
            neg6_reg  <= neg5_reg;
        end
    end

    // Stage 7: subnormal right shift with sticky collection.
    logic [233:0] wide7;
    logic [105:0] sh7;
    logic [52:0]  m7_reg;
    logic         g7_reg, s7_reg;
    logic [10:0]  ef7_reg;
    logic         ovf7_reg, nan7_reg, inf7_reg, zero7_reg, neg7_reg;

    assign wide7 = {n6_reg, 128'd0} >> rs6_reg;
    assign sh7   = wide7[233:128];

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            m7_reg    <= sh7[105:53];
            g7_reg    <= sh7[52];
            s7_reg    <= (sh7[51:0] != 52'd0) || (wide7[127:0] != 128'd0);
            ef7_reg   <= ef6_reg;
            ovf7_reg  <= ovf6_reg;
            nan7_reg  <= nan6_reg;
            inf7_reg  <= inf6_reg;
            zero7_reg <= zero6_reg;
            neg7_reg  <= neg6_reg;
        end
    end

    // Stage 8: pack and round.
    logic        rnd8;
    logic [10:0] em1_8;
    logic [62:0] packed8;
    prod_t       p8_reg;

    assign rnd8    = g7_reg & (s7_reg | m7_reg[0]);
    assign em1_8   = ef7_reg - 11'd1;
    assign packed8 = {em1_8, 52'd0} + {10'd0, m7_reg} + {62'd0, rnd8};

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            p8_reg.nan <= nan7_reg;
            p8_reg.neg <= neg7_reg;
            if (inf7_reg || (ovf7_reg && !zero7_reg))
            begin
                p8_reg.mag <= INF_MAG;
            end
            else if (zero7_reg)
            begin
                p8_reg.mag <= 63'd0;
            end
            else
            begin
                p8_reg.mag <= packed8;
            end
        end
    end

    assign prod = p8_reg;

endmodule

@@ src/tolerant_double_compare.sv @@
// ============================================================================
// Tolerant double compare
// Compares two IEEE-754 doubles within an absolute, relative or ULP tolerance.
// ============================================================================
// The block takes one pair of double bit patterns per transaction and returns
// one order code per transaction: 0 when the pair is equal within the selected
// tolerance, 1 when a is greater than b, and -1 otherwise or when either
// operand is NaN. It is a ten-stage pipeline: a new transaction can enter in
// every cycle unless a held-off output side has filled every stage. The
// pipeline depth is set by the relative test, where the largest magnitude is
// multiplied by the tolerance factor in four 27-bit partial products, summed,
// normalized and rounded; the subtractor for |a-b| runs alongside it in
// stages one to six. Stages that hold no transaction absorb a stall, so input
// keeps flowing while a result waits. Tolerances and the mode sit in registers
// on the configuration port (mode at byte 0, absolute tolerance at 8, relative
// factor at 16, ULP count at 24) and are meant to be written only while no
// transaction is in flight.
// ============================================================================
module tolerant_double_compare
    import tdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    // Operand channel.
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [63:0]       value_a,
    input  logic [63:0]       value_b,
    // Result channel.
    output logic              out_valid,
    input  logic              out_ready,
    output logic signed [1:0] order
);

    typedef struct packed {
        logic nan;
        logic gt;
        logic ulp;
    } flags_t;

    // ------------------------------------------------------------------
    // Configuration registers. The port never waits.
    // ------------------------------------------------------------------
    logic [2:0]  mode_reg;
    logic [63:0] abs_tol_reg;
    logic [63:0] rel_tol_reg;
    logic [31:0] ulp_tol_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_ABS;
            abs_tol_reg <= 64'd0;
            rel_tol_reg <= 64'd0;
            ulp_tol_reg <= 32'd0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:3])
                REG_MODE: mode_reg    <= pwdata[2:0];
                REG_ABS:  abs_tol_reg <= pwdata;
                REG_REL:  rel_tol_reg <= pwdata;
                REG_ULP:  ulp_tol_reg <= pwdata[31:0];
                default:  mode_reg    <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            REG_MODE: prdata = {61'd0, mode_reg};
            REG_ABS:  prdata = abs_tol_reg;
            REG_REL:  prdata = rel_tol_reg;
            REG_ULP:  prdata = {32'd0, ulp_tol_reg};
            default:  prdata = 64'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. A stage loads when it is empty or when the
    // stage after it moves, so bubbles close up behind a stalled output.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;

    always_comb
    begin
        en[LAST] = !v_reg[LAST] || out_ready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[LAST];

    // ------------------------------------------------------------------
    // Stage 0: operand register.
    // ------------------------------------------------------------------
    logic [63:0] a0_reg, b0_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a0_reg <= value_a;
            b0_reg <= value_b;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: NaN check, ordering, and the integer distance of the two
    // bit patterns for the ULP test.
    // ------------------------------------------------------------------
    logic        gt1;
    logic        nan1_reg, gt1_reg, sdiff1_reg, bothz1_reg;
    logic [63:0] dist1_reg;
    logic        zz1;

    assign zz1 = (a0_reg[62:0] == 63'd0) && (b0_reg[62:0] == 63'd0);

    always_comb
    begin
        if (zz1)
        begin
            gt1 = 1'b0;
        end
        else if (a0_reg[63] != b0_reg[63])
        begin
            gt1 = !a0_reg[63];
        end
        else if (!a0_reg[63])
        begin
            gt1 = a0_reg[62:0] > b0_reg[62:0];
        end
        else
        begin
            gt1 = a0_reg[62:0] < b0_reg[62:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            nan1_reg   <= is_nan63(a0_reg[62:0]) || is_nan63(b0_reg[62:0]);
            gt1_reg    <= gt1;
            sdiff1_reg <= a0_reg[63] != b0_reg[63];
            bothz1_reg <= zz1;
            dist1_reg  <= (a0_reg >= b0_reg) ? (a0_reg - b0_reg) : (b0_reg - a0_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: ULP verdict. Opposite signs only pass for the two zeros,
    // and with equal signs a negative count never passes.
    // ------------------------------------------------------------------
    flags_t fl_reg [2:LAST-1];
    logic   ulp2;

    assign ulp2 = sdiff1_reg ? bothz1_reg
                             : (!ulp_tol_reg[31] && (dist1_reg <= {32'd0, ulp_tol_reg}));

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            fl_reg[2] <= '{nan: nan1_reg, gt: gt1_reg, ulp: ulp2};
        end
        for (int k = 3; k <= LAST - 1; k++)
        begin
            if (en[k])
            begin
                fl_reg[k] <= fl_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Arithmetic: |a-b| and max(|a|,|b|) times the factor, both ready at
    // stage 8.
    // ------------------------------------------------------------------
    logic [62:0] big_mag;
    diff_t       diff;
    prod_t       prod;

    tdc_sub u_sub (
        .clk     (clk),
        .en      (en),
        .a       (a0_reg),
        .b       (b0_reg),
        .big_mag (big_mag),
        .diff    (diff)
    );

    tdc_mul u_mul (
        .clk     (clk),
        .en      (en),
        .big_mag (big_mag),
        .factor  (rel_tol_reg),
        .prod    (prod)
    );

    // ------------------------------------------------------------------
    // Stage 9: tolerance tests, mode selection and the order code.
    // ------------------------------------------------------------------
    logic               abs_ok, rel_ok, eq9;
    flags_t             fl8;
    logic signed [1:0]  order_reg;

    assign fl8    = fl_reg[LAST-1];
    assign abs_ok = tol_le(diff, abs_tol_reg[62:0], abs_tol_reg[63],
                           is_nan63(abs_tol_reg[62:0]));
    assign rel_ok = tol_le(diff, prod.mag, prod.neg, prod.nan);

    always_comb
    begin
        unique case (mode_reg)
            MODE_REL:     eq9 = rel_ok;
            MODE_ABS_REL: eq9 = abs_ok || rel_ok;
            MODE_ULP:     eq9 = fl8.ulp;
            MODE_ABS_ULP: eq9 = abs_ok || fl8.ulp;
            default:      eq9 = abs_ok;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[LAST])
        begin
            if (fl8.nan)
            begin
                order_reg <= ORDER_LT;
            end
            else if (eq9)
            begin
                order_reg <= ORDER_EQ;
            end
            else if (fl8.gt)
            begin
                order_reg <= ORDER_GT;
            end
            else
            begin
                order_reg <= ORDER_LT;
            end
        end
    end

    assign order = order_reg;

`ifndef SYNTHESIS
    // A ready output side must never hold off the input side.
    assert property (@(posedge clk) disable iff (!rst_n) out_ready |-> in_ready)
        else $error("input stalled while the output side is ready");

    // Only the three defined order codes ever leave the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (order == ORDER_EQ || order == ORDER_GT || order == ORDER_LT))
        else $error("undefined order code on a valid result");

    // A NaN operand always yields the less-than code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[LAST-1] && fl8.nan && en[LAST]) |=> (order == ORDER_LT))
        else $error("NaN operand did not produce the less-than code");

    // An accepted transaction occupies the first stage in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v_reg[0])
        else $error("accepted transaction lost at the input register");
`endif

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Tolerant double compare testbench
// Drives operand pairs and configuration writes into the comparator and checks
// every order code against a predictor built on the simulator's real type.
// ============================================================================
// Each named test task below exercises one part of the block: the absolute,
// relative and ULP tests with their mixed modes, the unused mode codes,
// output back-pressure and long random runs under changing tolerances. A
// shared task sends one transaction, and a single checking process compares
// every result with the oldest prediction waiting in the queue.
// ============================================================================
module testbench;
    import tdc_pkg::*;

    // Pipeline depth plus a margin; used before configuration writes and at the end.
    localparam int DRAIN_CYCLES = NSTG + 4;
    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] POS_ZERO = 64'h0000_0000_0000_0000;
    localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
    localparam logic [63:0] POS_INF  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] NEG_INF  = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] QNAN     = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] ONE      = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] TWO      = 64'h4000_0000_0000_0000;
    localparam logic [63:0] MAX_NORM = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_SUB  = 64'h0000_0000_0000_0001;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [4:0]        paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_ready;
    logic [63:0]       value_a;
    logic [63:0]       value_b;
    logic              out_valid;
    logic              out_ready;
    logic signed [1:0] order;

    // The testbench's own copy of the configuration registers.
    logic [2:0]         mode_q;
    logic [63:0]        abs_tol_q;
    logic [63:0]        rel_tol_q;
    logic signed [31:0] ulp_tol_q;

    logic signed [1:0] expected_orders[$];
    int                errors;
    bit                steady;      // When set, neither side idles at random.
    int                hold_off;    // Remaining cycles the receiver refuses results.

    tolerant_double_compare DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value_a   (value_a),
        .value_b   (value_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .order     (order)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("tolerant_double_compare test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic bit nan_bits(input logic [63:0] v);
        return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
    endfunction

    // True when |a-b| <= tol in double arithmetic; a NaN on either side fails.
    function automatic bit within_abs(input real a, input real b);
        logic [63:0] diff_bits;
        real         diff_mag;
        diff_bits = $realtobits(a - b);
        if (nan_bits(diff_bits) || nan_bits(abs_tol_q))
            return 1'b0;
        diff_mag = $bitstoreal({1'b0, diff_bits[62:0]});
        return diff_mag <= $bitstoreal(abs_tol_q);
    endfunction

    // True when |a-b| <= max(|a|,|b|) * factor.
    function automatic bit within_rel(input logic [63:0] ra, input logic [63:0] rb);
        logic [63:0] diff_bits;
        logic [63:0] bound_bits;
        real         mag_a;
        real         mag_b;
        real         largest;
        diff_bits = $realtobits($bitstoreal(ra) - $bitstoreal(rb));
        mag_a = $bitstoreal({1'b0, ra[62:0]});
        mag_b = $bitstoreal({1'b0, rb[62:0]});
        largest = (mag_a > mag_b) ? mag_a : mag_b;
        bound_bits = $realtobits(largest * $bitstoreal(rel_tol_q));
        if (nan_bits(diff_bits) || nan_bits(bound_bits))
            return 1'b0;
        return $bitstoreal({1'b0, diff_bits[62:0]}) <= $bitstoreal(bound_bits);
    endfunction

    // Distance of the raw patterns; across the sign only +0 and -0 match.
    function automatic bit within_ulp(input logic [63:0] ra, input logic [63:0] rb);
        logic [63:0] gap;
        if ((ra & SIGN_BIT) != (rb & SIGN_BIT))
            return (ra[62:0] == 63'd0) && (rb[62:0] == 63'd0);
        gap = (ra >= rb) ? ra - rb : rb - ra;
        if (ulp_tol_q < 0)
            return 1'b0;
        return gap <= 64'(ulp_tol_q);
    endfunction

    function automatic logic signed [1:0] predict_order(input logic [63:0] ra,
                                                        input logic [63:0] rb);
        real a;
        real b;
        bit  equal;
        if (nan_bits(ra) || nan_bits(rb))
            return ORDER_LT;
        a = $bitstoreal(ra);
        b = $bitstoreal(rb);
        case (mode_q)
            MODE_REL:     equal = within_rel(ra, rb);
            MODE_ABS_REL: equal = within_abs(a, b) || within_rel(ra, rb);
            MODE_ULP:     equal = within_ulp(ra, rb);
            MODE_ABS_ULP: equal = within_abs(a, b) || within_ulp(ra, rb);
            default:      equal = within_abs(a, b);
        endcase
        if (equal)
            return ORDER_EQ;
        return (a > b) ? ORDER_GT : ORDER_LT;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Two-phase register write; the register changes at the access edge.
    task automatic write_reg(input logic [1:0] index, input logic [63:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 3'b000};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_MODE: mode_q    = data[2:0];
            REG_ABS:  abs_tol_q = data;
            REG_REL:  rel_tol_q = data;
            default:  ulp_tol_q = data[31:0];
        endcase
    endtask

    // Waits until every predicted result has been seen, then lets the pipe drain.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_orders.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [2:0] m, input logic [63:0] abs_tol,
                             input logic [63:0] rel_tol, input logic [31:0] ulp_tol);
        drain();
        write_reg(REG_MODE, {61'd0, m});
        write_reg(REG_ABS, abs_tol);
        write_reg(REG_REL, rel_tol);
        write_reg(REG_ULP, {32'd0, ulp_tol});
    endtask

    // Offers one transaction and records its prediction once it is taken.
    task automatic send_pair(input logic [63:0] a, input logic [63:0] b);
        if (!steady && $urandom_range(99) < 20) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value_a  <= a;
        value_b  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        expected_orders.push_back(predict_order(a, b));
    endtask

    // ------------------------------------------------------------------
    // Result side: ready pattern and checker
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (hold_off > 0) begin
            out_ready <= 1'b0;
            hold_off  <= hold_off - 1;
        end
        else if (steady)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 17);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_orders.size() == 0) begin
                $display("%0t: unexpected result, order actual %0d", $time, order);
                errors++;
            end
            else begin
                if (order !== expected_orders[0]) begin
                    $display("%0t: order mismatch, expected %0d actual %0d",
                             $time, expected_orders[0], order);
                    errors++;
                end
                void'(expected_orders.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [63:0] random_bits();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] random_operand();
        case ($urandom_range(9))
            0: return random_bits();
            1: begin
                case ($urandom_range(7))
                    0: return POS_ZERO;
                    1: return NEG_ZERO;
                    2: return POS_INF;
                    3: return NEG_INF;
                    4: return QNAN | {12'd0, 52'($urandom())};
                    5: return MAX_NORM | ($urandom_range(1) ? SIGN_BIT : 64'd0);
                    6: return MIN_SUB | ($urandom_range(1) ? SIGN_BIT : 64'd0);
                    default: return ONE;
                endcase
            end
            // Moderate exponents keep the tolerance tests meaningful.
            default: return {1'($urandom_range(1)), 11'($urandom_range(1033, 1013)),
                             20'($urandom()), 32'($urandom())};
        endcase
    endfunction

    // A partner close to the given operand, often a few ULPs away.
    function automatic logic [63:0] nearby(input logic [63:0] a);
        case ($urandom_range(5))
            0: return a;
            1: return a + 64'($urandom_range(16));
            2: return a - 64'($urandom_range(16));
            3: return a + 64'($urandom_range(1 << 20));
            4: return a ^ SIGN_BIT;
            default: return random_operand();
        endcase
    endfunction

    function automatic logic [63:0] random_tolerance();
        case ($urandom_range(7))
            0: return POS_ZERO;
            1: return random_bits();
            2: return QNAN;
            3: return POS_INF;
            4: return {1'b1, 11'($urandom_range(1030, 990)), 52'(random_bits())};
            default: return {1'b0, 11'($urandom_range(1026, 960)), 52'(random_bits())};
        endcase
    endfunction

    function automatic logic [31:0] random_ulp();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return $urandom();
            default: return 32'($urandom_range(1 << 21));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Absolute mode at reset values, with the field extremes and special values.
    task automatic test_absolute();
        send_pair(POS_ZERO, NEG_ZERO);
        send_pair(ONE, ONE);
        send_pair(TWO, ONE);
        send_pair(ONE, TWO);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, ONE);
        send_pair(ONE, QNAN);
        send_pair(POS_INF, POS_INF);
        send_pair(POS_INF, NEG_INF);
        send_pair(MAX_NORM, MAX_NORM ^ SIGN_BIT);
        configure(MODE_ABS, ONE, POS_ZERO, 32'd0);
        send_pair(TWO, ONE);
        send_pair(TWO, MIN_SUB);
        // A negative tolerance only admits an exact zero difference.
        configure(MODE_ABS, ONE | SIGN_BIT, POS_ZERO, 32'd0);
        send_pair(ONE, ONE);
        send_pair(TWO, ONE);
        configure(MODE_ABS, QNAN, POS_ZERO, 32'd0);
        send_pair(ONE, ONE);
    endtask

    task automatic test_relative();
        configure(MODE_REL, POS_ZERO, 64'h3FE0_0000_0000_0000, 32'd0);
        send_pair(TWO, ONE);
        send_pair(64'h4008_0000_0000_0000, ONE);
        send_pair(POS_INF, ONE);
        send_pair(POS_ZERO, NEG_ZERO);
        configure(MODE_ABS_REL, 64'h3FB9_9999_9999_999A, POS_INF, 32'd0);
        send_pair(ONE, TWO);
        send_pair(POS_ZERO, POS_ZERO);
    endtask

    task automatic test_ulp();
        configure(MODE_ULP, POS_ZERO, POS_ZERO, 32'd2);
        send_pair(ONE, ONE + 64'd2);
        send_pair(ONE + 64'd3, ONE);
        send_pair(POS_ZERO, NEG_ZERO);
        send_pair(MIN_SUB, MIN_SUB | SIGN_BIT);
        send_pair(POS_INF, POS_INF);
        configure(MODE_ULP, POS_ZERO, POS_ZERO, 32'h8000_0000);
        send_pair(ONE, ONE);
        send_pair(NEG_ZERO, POS_ZERO);
        configure(MODE_ABS_ULP, ONE, POS_ZERO, 32'h7FFF_FFFF);
        send_pair(TWO, 64'h4010_0000_0000_0000);
        send_pair(64'hC000_0000_0000_0000, ONE);
    endtask

    // Codes five to seven fall back to the absolute test.
    task automatic test_unused_modes();
        for (int m = 5; m < 8; m++) begin
            configure(3'(m), ONE, POS_INF, 32'h7FFF_FFFF);
            send_pair(TWO, ONE);
            send_pair(64'h4010_0000_0000_0000, ONE);
        end
    endtask

    // The receiver refuses results long enough for the pipe to fill and the
    // input to stall; afterwards the sender pauses until everything is back.
    task automatic test_backpressure();
        configure(MODE_ABS_REL, random_tolerance(), random_tolerance(), random_ulp());
        steady = 1'b1;
        hold_off = 200;
        for (int i = 0; i < 40; i++)
            send_pair(random_operand(), random_operand());
        steady = 1'b0;
        drain();
    endtask

    task automatic test_random();
        logic [63:0] a;
        for (int phase = 0; phase < 26; phase++) begin
            if (phase == 0)
                configure(MODE_ABS, MAX_NORM, POS_ZERO, 32'd0);
            else if (phase == 1)
                configure(MODE_ULP, POS_ZERO, POS_ZERO, 32'h7FFF_FFFF);
            else
                configure(3'($urandom_range(7)), random_tolerance(), random_tolerance(),
                          random_ulp());
            // Every fourth phase runs without idling on either side.
            steady = (phase % 4 == 3);
            for (int i = 0; i < 52; i++) begin
                a = random_operand();
                if ($urandom_range(1))
                    send_pair(a, nearby(a));
                else
                    send_pair(nearby(a), a);
            end
            steady = 1'b0;
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        value_a   = '0;
        value_b   = '0;
        out_ready = 1'b0;
        mode_q    = MODE_ABS;
        abs_tol_q = '0;
        rel_tol_q = '0;
        ulp_tol_q = '0;
        errors    = 0;
        steady    = 1'b0;
        hold_off  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_absolute();
        test_relative();
        test_ulp();
        test_unused_modes();
        test_backpressure();
        test_random();
        drain();

        if (errors == 0)
            $display("tolerant_double_compare test passed");
        else
            $display("tolerant_double_compare test failed");
        $finish;
    end

endmodule

@@ tolerant_double_compare.f @@
src/tdc_pkg.sv
src/tdc_sub.sv
src/tdc_mul.sv
src/tolerant_double_compare.sv
dv/testbench.sv
